// ===== hdl/nbpua_pkg.sv =====
// shared types and constants for the nine-bit over parity uart adapter
package nbpua_pkg;

	// line parity modes, coded as on the transmit result
	typedef enum logic [1:0] {
		MODE_ODD   = 2'd0,
		MODE_EVEN  = 2'd1,
		MODE_SPACE = 2'd2,
		MODE_MARK  = 2'd3
	} mode_t;

	// escape tracking on the receive stream
	typedef enum logic [1:0] {
		MRK_IDLE = 2'd0,
		MRK_FF   = 2'd1,
		MRK_FF00 = 2'd2
	} marker_t;

	// transaction opcodes and result kinds
	localparam logic OP_RX   = 1'b0;
	localparam logic OP_TX   = 1'b1;
	localparam logic KIND_RX = 1'b0;
	localparam logic KIND_TX = 1'b1;

	// parity scheme register values
	localparam logic SCHEME_SPACE_MARK = 1'b0;
	localparam logic SCHEME_EVEN_ODD   = 1'b1;

	// marker bytes of the receive stream
	localparam logic [7:0] BYTE_ESC  = 8'hFF;
	localparam logic [7:0] BYTE_ZERO = 8'h00;

	// input transaction payload
	typedef struct packed {
		logic       opcode;
		logic [7:0] line_byte;
		logic [8:0] send_word;
	} in_item_t;

	// result transaction payload
	typedef struct packed {
		logic       result_kind;
		logic [8:0] rx_word;
		logic       rx_parity_error;
		logic       rx_malformed;
		logic [7:0] tx_byte;
		logic [1:0] tx_parity_mode;
		logic       mode_changed;
	} out_item_t;

	// state carried from one transaction to the next
	typedef struct packed {
		marker_t marker;
		mode_t   mode;
	} step_state_t;

	// idle mode that a scheme starts from
	function automatic mode_t idle_mode(input logic scheme);
		return (scheme == SCHEME_EVEN_ODD) ? MODE_EVEN : MODE_SPACE;
	endfunction

endpackage

// ===== hdl/nbpua_if.sv =====
// valid/ready channel interfaces for input and result transactions
interface nbpua_in_if;
	logic                valid;
	logic                ready;
	nbpua_pkg::in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface nbpua_out_if;
	logic                 valid;
	logic                 ready;
	nbpua_pkg::out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ===== hdl/nbpua_step.sv =====
// combinational decode/encode of one transaction against the current state
module nbpua_step (
	input  nbpua_pkg::in_item_t    item,
	input  logic                   scheme,
	input  nbpua_pkg::step_state_t cur,
	output nbpua_pkg::step_state_t nxt,
	output logic                   emit,
	output nbpua_pkg::out_item_t   result
);

	logic            byte_par;
	logic            err;
	logic            ninth;
	logic            malformed;
	nbpua_pkg::mode_t tx_mode;

	// parity of the received byte
	assign byte_par = ^item.line_byte;

	// mode that puts bit 8 of the send word on the line
	always_comb begin
		if (scheme == nbpua_pkg::SCHEME_EVEN_ODD) begin
			tx_mode = ((^item.send_word[7:0]) != item.send_word[8]) ?
				nbpua_pkg::MODE_ODD : nbpua_pkg::MODE_EVEN;
		end else begin
			tx_mode = item.send_word[8] ? nbpua_pkg::MODE_MARK : nbpua_pkg::MODE_SPACE;
		end
	end

	// rebuild the ninth bit from the current mode and the error flag
	always_comb begin
		case (cur.mode)
			nbpua_pkg::MODE_SPACE: ninth = err;
			nbpua_pkg::MODE_MARK:  ninth = ~err;
			nbpua_pkg::MODE_EVEN:  ninth = byte_par ^ err;
			default:               ninth = ~(byte_par ^ err);
		endcase
	end

	// next state of the escape tracker and the mode
	always_comb begin
		nxt = cur;
		if (item.opcode == nbpua_pkg::OP_TX) begin
			nxt.mode = tx_mode;
		end else begin
			unique case (cur.marker)
				nbpua_pkg::MRK_FF: begin
					nxt.marker = (item.line_byte == nbpua_pkg::BYTE_ZERO) ?
						nbpua_pkg::MRK_FF00 : nbpua_pkg::MRK_IDLE;
				end
				nbpua_pkg::MRK_FF00: begin
					nxt.marker = nbpua_pkg::MRK_IDLE;
				end
				default: begin
					nxt.marker = (item.line_byte == nbpua_pkg::BYTE_ESC) ?
						nbpua_pkg::MRK_FF : nbpua_pkg::MRK_IDLE;
				end
			endcase
		end
	end

	// result outputs per escape state
	always_comb begin
		emit      = 1'b1;
		err       = 1'b0;
		malformed = 1'b0;
		unique case (cur.marker)
			nbpua_pkg::MRK_FF: begin
				emit      = (item.line_byte != nbpua_pkg::BYTE_ZERO);
				malformed = (item.line_byte != nbpua_pkg::BYTE_ESC);
			end
			nbpua_pkg::MRK_FF00: begin
				err = 1'b1;
			end
			default: begin
				emit = (item.line_byte != nbpua_pkg::BYTE_ESC);
			end
		endcase
		if (item.opcode == nbpua_pkg::OP_TX) begin
			emit = 1'b1;
		end
	end

	// assemble the result transaction
	always_comb begin
		result = '0;
		if (item.opcode == nbpua_pkg::OP_TX) begin
			result.result_kind    = nbpua_pkg::KIND_TX;
			result.tx_byte        = item.send_word[7:0];
			result.tx_parity_mode = tx_mode;
			result.mode_changed   = (tx_mode != cur.mode);
		end else begin
			result.result_kind     = nbpua_pkg::KIND_RX;
			result.rx_word         = malformed ? 9'd0 : {ninth, item.line_byte};
			result.rx_parity_error = err;
			result.rx_malformed    = malformed;
		end
	end

endmodule

// ===== hdl/nine_bit_over_parity_uart_adapter.sv =====
// Nine-bit word adapter for an eight-bit UART that carries bit 8 in the parity bit.
// Receive transactions take one byte of a parity-marked stream (FF 00 x flags a parity
// error on x, FF FF is a literal FF) and give a nine-bit word once a byte completes it;
// send transactions give the byte and parity mode to put on the line. One transaction
// is accepted every cycle while cmd.ready is high; each passes through an input register
// and then a result register, in which any result that it gives is held until it is
// taken by the receiver through res.ready. cmd.ready drops only when both registers are
// full and res.ready is low. Write cfg_wdata only while idle; a write also reloads the
// current mode with the scheme's idle mode.
module nine_bit_over_parity_uart_adapter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	nbpua_in_if.sink          cmd,
	nbpua_out_if.source       res
);

	nbpua_pkg::in_item_t    item_s1;
	logic                   valid_s1;
	nbpua_pkg::step_state_t state_q;
	nbpua_pkg::step_state_t state_nxt;
	logic                   scheme_q;
	nbpua_pkg::out_item_t   res_item_q;
	logic                   res_valid_q;
	logic                   emit;
	nbpua_pkg::out_item_t   result;
	logic                   advance;

	// the stage moves on when the result register is free or being emptied
	assign advance   = !res_valid_q || res.ready;
	assign cmd.ready = !valid_s1 || advance;
	assign res.valid = res_valid_q;
	assign res.item  = res_item_q;

	// per-transaction logic
	nbpua_step u_step (
		.item   (item_s1),
		.scheme (scheme_q),
		.cur    (state_q),
		.nxt    (state_nxt),
		.emit   (emit),
		.result (result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1 <= cmd.item;
		end
	end

	// scheme register and carried state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scheme_q       <= nbpua_pkg::SCHEME_SPACE_MARK;
			state_q.marker <= nbpua_pkg::MRK_IDLE;
			state_q.mode   <= nbpua_pkg::MODE_SPACE;
		end else if (cfg_we) begin
			scheme_q     <= cfg_wdata;
			state_q.mode <= nbpua_pkg::idle_mode(cfg_wdata);
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			res_item_q <= result;
		end
	end

endmodule

// ===== tb/tb_nine_bit_over_parity_uart_adapter.sv =====
// self-checking testbench for the nine-bit over parity uart adapter
module tb_nine_bit_over_parity_uart_adapter;
	timeunit 1ns;
	timeprecision 1ps;

	import nbpua_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	nbpua_in_if  cmd_ch ();
	nbpua_out_if res_ch ();

	nine_bit_over_parity_uart_adapter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	// 8 ns clock
	always #4 clk = ~clk;

	// commands waiting to be offered and results predicted but not yet seen
	in_item_t  queued_cmds[$];
	out_item_t predicted_res[$];

	// shadow copy of the adapter state
	logic    scheme_q = SCHEME_SPACE_MARK;
	mode_t   mode_q   = MODE_SPACE;
	marker_t marker_q = MRK_IDLE;

	logic        drive_on = 1'b0;
	logic        cmd_taken = 1'b0;
	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	int unsigned stall_requests = 0;
	int unsigned stall_served = 0;
	int unsigned hold_left = 0;
	int unsigned n_mismatch = 0;

	// ninth bit rebuilt from the mode the line was in
	function automatic logic rx_ninth_bit(mode_t m, logic [7:0] b, logic err);
		case (m)
			MODE_SPACE: return err;
			MODE_MARK:  return ~err;
			MODE_EVEN:  return (^b) ^ err;
			default:    return ~((^b) ^ err);
		endcase
	endfunction

	// work out the result of one accepted transaction and advance the shadow state
	task automatic predict_adapter(input in_item_t c);
		out_item_t r;
		mode_t     m;
		r = '0;
		if (c.opcode == OP_TX) begin
			if (scheme_q == SCHEME_EVEN_ODD)
				m = ((^c.send_word[7:0]) != c.send_word[8]) ? MODE_ODD : MODE_EVEN;
			else
				m = c.send_word[8] ? MODE_MARK : MODE_SPACE;
			r.result_kind    = KIND_TX;
			r.tx_byte        = c.send_word[7:0];
			r.tx_parity_mode = m;
			r.mode_changed   = (m != mode_q);
			mode_q = m;
			predicted_res.push_back(r);
		end else begin
			r.result_kind = KIND_RX;
			case (marker_q)
				MRK_FF: begin
					if (c.line_byte == BYTE_ZERO) begin
						marker_q = MRK_FF00;
					end else begin
						marker_q = MRK_IDLE;
						if (c.line_byte == BYTE_ESC)
							r.rx_word = {rx_ninth_bit(mode_q, BYTE_ESC, 1'b0), BYTE_ESC};
						else
							r.rx_malformed = 1'b1;
						predicted_res.push_back(r);
					end
				end
				MRK_FF00: begin
					marker_q = MRK_IDLE;
					r.rx_word = {rx_ninth_bit(mode_q, c.line_byte, 1'b1), c.line_byte};
					r.rx_parity_error = 1'b1;
					predicted_res.push_back(r);
				end
				default: begin
					if (c.line_byte == BYTE_ESC) begin
						marker_q = MRK_FF;
					end else begin
						marker_q = MRK_IDLE;
						r.rx_word = {rx_ninth_bit(mode_q, c.line_byte, 1'b0), c.line_byte};
						predicted_res.push_back(r);
					end
				end
			endcase
		end
	endtask

	task automatic check_field(input string fname, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			n_mismatch++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
		end
	endtask

	// track config writes and accepted commands, check each result transaction
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		cmd_taken <= drive_on && cmd_ch.valid && cmd_ch.ready;
		if (arst_n) begin
			if (cfg_we) begin
				scheme_q = cfg_wdata;
				mode_q   = (cfg_wdata == SCHEME_EVEN_ODD) ? MODE_EVEN : MODE_SPACE;
			end
			if (cmd_ch.valid && cmd_ch.ready)
				predict_adapter(cmd_ch.item);
			if (res_ch.valid && res_ch.ready) begin
				got = res_ch.item;
				if (predicted_res.size() == 0) begin
					n_mismatch++;
					$display("%0t: result with nothing expected, expected none, actual %p",
						$time, got);
				end else begin
					want = predicted_res.pop_front();
					check_field("result_kind", want.result_kind, got.result_kind);
					check_field("rx_word", want.rx_word, got.rx_word);
					check_field("rx_parity_error", want.rx_parity_error, got.rx_parity_error);
					check_field("rx_malformed", want.rx_malformed, got.rx_malformed);
					check_field("tx_byte", want.tx_byte, got.tx_byte);
					check_field("tx_parity_mode", want.tx_parity_mode, got.tx_parity_mode);
					check_field("mode_changed", want.mode_changed, got.mode_changed);
				end
			end
		end
	end

	// command driver: hold an offer until taken, otherwise offer the next or idle
	always @(negedge clk) begin
		if (drive_on) begin
			if (!(cmd_ch.valid && !cmd_taken)) begin
				if (queued_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					cmd_ch.valid <= 1'b1;
					cmd_ch.item  <= queued_cmds.pop_front();
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result receiver with random stalls and a long hold-off when one is requested
	always @(negedge clk) begin
		if (drive_on) begin
			if (stall_served != stall_requests) begin
				hold_left = 300;
				stall_served++;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	task automatic add_rx(input logic [7:0] b);
		in_item_t c;
		c.opcode    = OP_RX;
		c.line_byte = b;
		c.send_word = 9'($urandom);
		queued_cmds.push_back(c);
	endtask

	task automatic add_tx(input logic [8:0] w);
		in_item_t c;
		c.opcode    = OP_TX;
		c.line_byte = 8'($urandom);
		c.send_word = w;
		queued_cmds.push_back(c);
	endtask

	// wait for the block to drain, then let in-flight marker bytes settle
	task automatic wait_idle();
		while (queued_cmds.size() != 0 || cmd_ch.valid || predicted_res.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_scheme(input logic v);
		wait_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// mostly well-formed receive bytes and escape sequences with random content, sends, some broken ones
	task automatic add_random(input int unsigned n_items);
		int unsigned n;
		int unsigned pick;
		logic [7:0]  b;
		n = 0;
		while (n < n_items) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				b = ($urandom_range(9) == 0) ? BYTE_ZERO : 8'($urandom_range(254));
				add_rx(b);
				n += 1;
			end else if (pick < 45) begin
				add_rx(BYTE_ESC);
				add_rx(BYTE_ESC);
				n += 2;
			end else if (pick < 60) begin
				add_rx(BYTE_ESC);
				add_rx(BYTE_ZERO);
				case ($urandom_range(5))
					0:       add_rx(BYTE_ESC);
					1:       add_rx(BYTE_ZERO);
					default: add_rx(8'($urandom));
				endcase
				n += 3;
			end else if (pick < 65) begin
				add_rx(BYTE_ESC);
				add_rx(8'($urandom_range(254, 1)));
				n += 2;
			end else if (pick < 95) begin
				add_tx(9'($urandom));
				n += 1;
			end else begin
				add_rx(8'($urandom));
				n += 1;
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.item  = '0;
		res_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n   <= 1'b1;
		drive_on <= 1'b1;

		// sender mostly busy, receiver mostly stalled
		src_idle_pct = 12;
		snk_idle_pct = 82;
		write_scheme(SCHEME_SPACE_MARK);
		// plain bytes, escapes, error markers and a malformed escape in space mode
		add_rx(8'h00);
		add_rx(8'h7F);
		add_rx(8'h80);
		add_rx(8'hFE);
		add_rx(BYTE_ESC); add_rx(BYTE_ESC);
		add_rx(BYTE_ESC); add_rx(BYTE_ZERO); add_rx(8'h55);
		add_rx(BYTE_ESC); add_rx(BYTE_ZERO); add_rx(BYTE_ESC);
		add_rx(BYTE_ESC); add_rx(BYTE_ZERO); add_rx(BYTE_ZERO);
		add_rx(BYTE_ESC); add_rx(8'h12);
		// sends, receive in mark mode, send in the middle of an escape
		add_tx(9'h000);
		add_tx(9'h100);
		add_rx(8'h01);
		add_rx(BYTE_ESC);
		add_tx(9'h1FF);
		add_rx(BYTE_ESC);
		add_tx(9'h0FF);
		write_scheme(SCHEME_EVEN_ODD);
		// even/odd scheme, leaving an escape open across the next scheme write
		add_tx(9'h001);
		add_rx(8'h81);
		add_rx(BYTE_ESC); add_rx(BYTE_ZERO); add_rx(8'h01);
		add_tx(9'h100);
		add_rx(BYTE_ESC);
		write_scheme(SCHEME_EVEN_ODD);
		add_random(400);

		// sender mostly idle, receiver mostly ready
		src_idle_pct = 82;
		snk_idle_pct = 12;
		write_scheme(SCHEME_SPACE_MARK);
		add_random(400);

		// no idling, with one long receiver hold-off to back the block up
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_scheme(SCHEME_EVEN_ODD);
		add_random(400);
		stall_requests++;
		write_scheme(SCHEME_SPACE_MARK);
		add_random(60);

		wait_idle();
		repeat (10) @(posedge clk);
		if (n_mismatch == 0) begin
			$display("tb_nine_bit_over_parity_uart_adapter: done, clean");
		end else begin
			$display("tb_nine_bit_over_parity_uart_adapter: done, errors");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("tb_nine_bit_over_parity_uart_adapter: done, errors");
		$finish;
	end

endmodule

// ===== nine_bit_over_parity_uart_adapter.f =====
hdl/nbpua_pkg.sv
hdl/nbpua_if.sv
hdl/nbpua_step.sv
hdl/nine_bit_over_parity_uart_adapter.sv
tb/tb_nine_bit_over_parity_uart_adapter.sv
